// File: design/scdl_pkg.sv
`default_nettype none
package scdl_pkg;

  localparam int DELAY_DEPTH_DEF = 1024;
  localparam int SINE_SIZE_DEF   = 1024;

  localparam int SMP_W      = 24;
  localparam int AMT_W      = 13;
  localparam int WID_W      = 13;
  localparam int STEP_W     = 24;
  localparam int DLY_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd4;

  localparam logic [AMT_W-1:0]  AMOUNT_RST = 13'd0;
  localparam logic [WID_W-1:0]  WIDTH_RST  = 13'd2048;
  localparam logic [STEP_W-1:0] STEP_RST   = 24'd44739;
  localparam logic [DLY_W-1:0]  BASE_RST   = 16'd36864;
  localparam logic [DLY_W-1:0]  DEPTH_RST  = 16'd24576;

  // wet amount at or below this passes the input straight through
  localparam logic [AMT_W-1:0] BYPASS_MAX = 13'd4;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
  } scdl_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
  } scdl_out_t;

  // Q1.15 sine entry from an odd quarter-wave polynomial in Q30, floored products
  function automatic logic signed [15:0] sine_entry_f(input int unsigned idx,
                                                      input int unsigned log_size);
    logic [31:0] tw;
    logic [1:0]  quad;
    longint      z;
    longint      z2;
    longint      acc;
    tw   = 32'(longint'(idx) << (32 - log_size));
    quad = tw[31:30];
    z    = longint'({34'd0, tw[29:0]});
    if (quad[0]) begin
      z = 64'sd1073741824 - z;
    end
    z2  = (z * z) >>> 30;
    acc = 64'sd172271;
    acc = -64'sd5026994 + ((acc * z2) >>> 30);
    acc = 64'sd85569306 + ((acc * z2) >>> 30);
    acc = -64'sd693598668 + ((acc * z2) >>> 30);
    acc = 64'sd1686629713 + ((acc * z2) >>> 30);
    acc = (acc * z) >>> 30;
    acc = (acc + 64'sd16384) >>> 15;
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > 32767) begin
      acc = 32767;
    end
    return quad[1] ? 16'(-acc) : 16'(acc);
  endfunction

endpackage
`default_nettype wire

// File: design/stereo_chorus_delay_line_unit.sv
`default_nettype none
// Stereo chorus: an LFO-modulated fractional delay on each channel of a
// 24-bit stereo stream, one output pair per input pair.
// Input channel in_valid/in_stall/in_data carries a left/right sample pair;
// output channel out_valid/out_stall/out_data returns the mixed pair.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the five control registers
// (amount, width, LFO step, base delay, depth); cfg_ready is high out of reset.
// Write configuration only while no request is in flight.
// A chorus request runs through one sequencer: two reads of the sine ROM
// port, two reads of each delay ring port and a chain of five registered
// multiplies before out_valid rises. A new request is accepted the cycle
// after the result moves to the output register, so requests never overlap.
// With amount at or below 4 the input pair goes through the result register
// and the output register to out_valid, and the LFO phase, the write index
// and the delay rings do not move.
// The output register holds a result while out_stall is high; the input is
// taken even while it waits, and the sequencer holds at its last step if
// the next result finds the register still full.
// Reset (rst_n low, synchronous) holds in_stall high and cfg_ready low, returns
// registers to defaults and clears the LFO phase, the write index and the ring
// fill flag; ring entries not yet written since reset read as zero.
// DELAY_DEPTH and SINE_TABLE_SIZE must be powers of two; the block does not check it.
module stereo_chorus_delay_line_unit #(
  parameter int DELAY_DEPTH     = scdl_pkg::DELAY_DEPTH_DEF,
  parameter int SINE_TABLE_SIZE = scdl_pkg::SINE_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire scdl_pkg::scdl_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output scdl_pkg::scdl_out_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [scdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scdl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scdl_pkg::*;

  localparam int LOGD = $clog2(DELAY_DEPTH);
  localparam int LOGS = $clog2(SINE_TABLE_SIZE);
  localparam int PW   = 16 + LOGD;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ROM0 = 4'd1;
  localparam logic [3:0] ST_ROM1 = 4'd2;
  localparam logic [3:0] ST_LFO0 = 4'd3;
  localparam logic [3:0] ST_LFO1 = 4'd4;
  localparam logic [3:0] ST_OFF  = 4'd5;
  localparam logic [3:0] ST_POS  = 4'd6;
  localparam logic [3:0] ST_RD0  = 4'd7;
  localparam logic [3:0] ST_RD1  = 4'd8;
  localparam logic [3:0] ST_WET0 = 4'd9;
  localparam logic [3:0] ST_WET1 = 4'd10;
  localparam logic [3:0] ST_MIX0 = 4'd11;
  localparam logic [3:0] ST_MIX1 = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  // control registers
  logic [AMT_W-1:0]   amount_r;
  logic [WID_W-1:0]   width_r;
  logic [STEP_W-1:0]  step_r;
  logic [DLY_W-1:0]   base_r;
  logic [DLY_W-1:0]   depth_r;

  logic [3:0]         state_r;
  logic [3:0]         state_nxt;
  logic               byp_r;
  logic [PHASE_W-1:0] phase_r;
  logic [LOGD-1:0]    wi_r;
  logic               full_r;
  logic               out_valid_r;
  scdl_out_t          out_data_r;

  logic               accept;
  logic               bypass;
  logic               out_load;

  // datapath registers
  logic signed [SMP_W-1:0] l_dry_r, r_dry_r;
  logic [28:0]             dw_r;
  logic signed [15:0]      rom_q_r;
  logic signed [15:0]      s0_r;
  logic signed [33:0]      lprod_r;
  logic signed [15:0]      lfo_r;
  logic signed [45:0]      oprod_r;
  logic [PW-1:0]           l_pos_r, r_pos_r;
  logic signed [SMP_W-1:0] l_q_r, r_q_r;
  logic                    l_qv_r, r_qv_r;
  logic signed [SMP_W-1:0] l_r0_r, r_r0_r;
  logic signed [41:0]      l_wprod_r, r_wprod_r;
  logic signed [24:0]      l_md_r, r_md_r;
  logic signed [38:0]      l_mprod_r, r_mprod_r;
  logic signed [SMP_W-1:0] l_res_r, r_res_r;

  // memories and constant table
  logic signed [SMP_W-1:0] l_ring [DELAY_DEPTH];
  logic signed [SMP_W-1:0] r_ring [DELAY_DEPTH];
  logic signed [15:0]      sine_rom [SINE_TABLE_SIZE];

  logic [LOGS-1:0]         rom_addr;
  logic [15:0]             lfo_frac;
  logic [LOGD-1:0]         l_raddr, r_raddr;
  logic                    l_rvalid, r_rvalid;
  logic                    ring_we;

  logic signed [16:0]      ldiff;
  logic signed [17:0]      lfo_sum;
  logic signed [26:0]      off;
  logic [31:0]             off_ext;
  logic [31:0]             pos_base;
  logic [31:0]             l_pos_full, r_pos_full;
  logic signed [SMP_W-1:0] l_q1, r_q1;
  logic signed [24:0]      l_d, r_d;
  logic signed [25:0]      l_wet, r_wet;
  logic signed [25:0]      l_md, r_md;
  logic signed [SMP_W-1:0] l_sat, r_sat;

  function automatic logic signed [SMP_W-1:0] mix_sat_f(input logic signed [SMP_W-1:0] dry,
                                                        input logic signed [38:0] mprod);
    logic signed [39:0] sum;
    logic signed [26:0] v;
    sum = $signed({{3{dry[SMP_W-1]}}, dry, 13'd0}) + $signed({mprod[38], mprod})
          + 40'sd4096;
    v   = sum[39:13];
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[SMP_W-1:0];
  endfunction

  for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
    assign sine_rom[g] = sine_entry_f(g, LOGS);
  end

  assign cfg_ready = rst_n;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign bypass    = (amount_r <= BYPASS_MAX);
  assign ring_we   = accept && !bypass;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amount_r <= AMOUNT_RST;
      width_r  <= WIDTH_RST;
      step_r   <= STEP_RST;
      base_r   <= BASE_RST;
      depth_r  <= DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AMOUNT: amount_r <= cfg_data[AMT_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        CFG_STEP:   step_r   <= cfg_data[STEP_W-1:0];
        CFG_BASE:   base_r   <= cfg_data[DLY_W-1:0];
        CFG_DEPTH:  depth_r  <= cfg_data[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = bypass ? ST_FIN : ST_ROM0;
        end
      end
      ST_ROM0: state_nxt = ST_ROM1;
      ST_ROM1: state_nxt = ST_LFO0;
      ST_LFO0: state_nxt = ST_LFO1;
      ST_LFO1: state_nxt = ST_OFF;
      ST_OFF:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_WET0;
      ST_WET0: state_nxt = ST_WET1;
      ST_WET1: state_nxt = ST_MIX0;
      ST_MIX0: state_nxt = ST_MIX1;
      ST_MIX1: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      byp_r       <= 1'b0;
      phase_r     <= '0;
      wi_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        byp_r <= bypass;
        if (!bypass) begin
          phase_r <= phase_r + PHASE_W'(step_r);
        end
      end
      // advance the write slot once the result leaves
      if (out_load && !byp_r) begin
        wi_r <= wi_r + LOGD'(1);
        if (wi_r == LOGD'(DELAY_DEPTH - 1)) begin
          full_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sine ROM: first entry, then its neighbor (wraps to entry 0)
  assign rom_addr = phase_r[PHASE_W-1 -: LOGS] + LOGS'(state_r == ST_ROM1);
  assign lfo_frac = phase_r[PHASE_W-1-LOGS -: 16];

  always_ff @(posedge clk) begin
    rom_q_r <= sine_rom[rom_addr];
  end

  // ring read: floor of position, then the next slot; unwritten slots read zero
  assign l_raddr  = l_pos_r[PW-1:16] + LOGD'(state_r == ST_RD1);
  assign r_raddr  = r_pos_r[PW-1:16] + LOGD'(state_r == ST_RD1);
  assign l_rvalid = full_r || (l_raddr <= wi_r);
  assign r_rvalid = full_r || (r_raddr <= wi_r);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      l_ring[wi_r] <= in_data.left_sample;
      r_ring[wi_r] <= in_data.right_sample;
    end
    l_q_r  <= l_ring[l_raddr];
    r_q_r  <= r_ring[r_raddr];
    l_qv_r <= l_rvalid;
    r_qv_r <= r_rvalid;
  end

  assign ldiff    = $signed({rom_q_r[15], rom_q_r}) - $signed({s0_r[15], s0_r});
  assign lfo_sum  = $signed({{2{s0_r[15]}}, s0_r}) + lprod_r[33:16];
  assign off      = oprod_r[45:19];
  assign off_ext  = {{5{off[26]}}, off};
  assign pos_base = (32'(wi_r) << 16) - (32'(base_r) << 8);
  assign l_pos_full = pos_base - off_ext;
  assign r_pos_full = pos_base + off_ext;

  assign l_q1  = l_qv_r ? l_q_r : '0;
  assign r_q1  = r_qv_r ? r_q_r : '0;
  assign l_d   = $signed({l_q1[SMP_W-1], l_q1}) - $signed({l_r0_r[SMP_W-1], l_r0_r});
  assign r_d   = $signed({r_q1[SMP_W-1], r_q1}) - $signed({r_r0_r[SMP_W-1], r_r0_r});
  assign l_wet = $signed({{2{l_r0_r[SMP_W-1]}}, l_r0_r}) + l_wprod_r[41:16];
  assign r_wet = $signed({{2{r_r0_r[SMP_W-1]}}, r_r0_r}) + r_wprod_r[41:16];
  assign l_md  = l_wet - $signed({{2{l_dry_r[SMP_W-1]}}, l_dry_r});
  assign r_md  = r_wet - $signed({{2{r_dry_r[SMP_W-1]}}, r_dry_r});
  assign l_sat = mix_sat_f(l_dry_r, l_mprod_r);
  assign r_sat = mix_sat_f(r_dry_r, r_mprod_r);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          l_dry_r <= in_data.left_sample;
          r_dry_r <= in_data.right_sample;
          l_res_r <= in_data.left_sample;
          r_res_r <= in_data.right_sample;
          dw_r    <= depth_r * width_r;
        end
      end
      ST_ROM1: s0_r    <= rom_q_r;
      ST_LFO0: lprod_r <= ldiff * $signed({1'b0, lfo_frac});
      ST_LFO1: lfo_r   <= lfo_sum[15:0];
      ST_OFF:  oprod_r <= $signed({1'b0, dw_r}) * lfo_r;
      ST_POS: begin
        l_pos_r <= l_pos_full[PW-1:0];
        r_pos_r <= r_pos_full[PW-1:0];
      end
      ST_RD1: begin
        l_r0_r <= l_qv_r ? l_q_r : '0;
        r_r0_r <= r_qv_r ? r_q_r : '0;
      end
      ST_WET0: begin
        l_wprod_r <= l_d * $signed({1'b0, l_pos_r[15:0]});
        r_wprod_r <= r_d * $signed({1'b0, r_pos_r[15:0]});
      end
      ST_WET1: begin
        l_md_r <= l_md[24:0];
        r_md_r <= r_md[24:0];
      end
      ST_MIX0: begin
        l_mprod_r <= l_md_r * $signed({1'b0, amount_r});
        r_mprod_r <= r_md_r * $signed({1'b0, amount_r});
      end
      ST_MIX1: begin
        l_res_r <= l_sat;
        r_res_r <= r_sat;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r.left_out  <= l_res_r;
      out_data_r.right_out <= r_res_r;
    end
  end

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |=> $stable(phase_r))
    else $error("LFO phase moved while a request was in flight");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && out_stall |=> state_r == ST_FIN && out_valid_r)
    else $error("result dropped while output register was full");

  a_wi_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !byp_r |=> wi_r == $past(wi_r) + LOGD'(1))
    else $error("write index did not advance after a chorus result");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    accept && bypass |=> state_r == ST_FIN && $stable(wi_r) && $stable(phase_r))
    else $error("bypass request touched chorus state");

endmodule
`default_nettype wire

// File: tb/stereo_chorus_delay_line_unit_test.sv
`default_nettype none
module stereo_chorus_delay_line_unit_test;
  import scdl_pkg::*;

  localparam int RING_N  = DELAY_DEPTH_DEF;
  localparam int RING_AW = $clog2(RING_N);
  localparam int SINE_N  = SINE_SIZE_DEF;
  localparam int SINE_AW = $clog2(SINE_N);

  // Expected output pairs of the chorus, computed from its own copy of the
  // registers, the LFO phase, the write index and both delay rings.
  class chorus_predictor;
    logic [AMT_W-1:0]        amount;
    logic [WID_W-1:0]        width;
    logic [STEP_W-1:0]       step;
    logic [DLY_W-1:0]        base;
    logic [DLY_W-1:0]        depth;
    logic [PHASE_W-1:0]      phase;
    logic [RING_AW-1:0]      wr_idx;
    logic signed [SMP_W-1:0] left_ring [RING_N];
    logic signed [SMP_W-1:0] right_ring [RING_N];
    longint                  sine_q15 [SINE_N];
    scdl_out_t               expected_pairs [$];
    int                      fails;

    function new();
      amount = AMOUNT_RST;
      width  = WIDTH_RST;
      step   = STEP_RST;
      base   = BASE_RST;
      depth  = DEPTH_RST;
      phase  = '0;
      wr_idx = '0;
      fails  = 0;
      for (int i = 0; i < RING_N; i++) begin
        left_ring[i]  = '0;
        right_ring[i] = '0;
      end
      for (int k = 0; k < SINE_N; k++) begin
        sine_q15[k] = sine_q15_at(k);
      end
    endfunction

    // Odd quarter-wave polynomial in Q30, Horner form, each product floored.
    function longint sine_q15_at(int unsigned k);
      logic [31:0] turn;
      longint      coef [5];
      longint      x;
      longint      x2;
      longint      p;
      coef = '{64'sd172271, -64'sd5026994, 64'sd85569306, -64'sd693598668,
               64'sd1686629713};
      turn = 32'((longint'(k) << 32) / SINE_N);
      x = longint'(turn[29:0]);
      if (turn[30]) begin
        x = (longint'(1) << 30) - x;
      end
      x2 = (x * x) >>> 30;
      p  = coef[0];
      for (int j = 1; j < 5; j++) begin
        p = coef[j] + ((p * x2) >>> 30);
      end
      p = (p * x) >>> 30;
      p = (p + 16384) >>> 15;
      if (p < 0) begin
        p = 0;
      end
      if (p > 32767) begin
        p = 32767;
      end
      return turn[31] ? -p : p;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_AMOUNT: amount = val[AMT_W-1:0];
        CFG_WIDTH:  width  = val[WID_W-1:0];
        CFG_STEP:   step   = val[STEP_W-1:0];
        CFG_BASE:   base   = val[DLY_W-1:0];
        CFG_DEPTH:  depth  = val[DLY_W-1:0];
        default: ;
      endcase
    endfunction

    // Floor the read position so the fraction stays in [0,1); wrap the index.
    function longint fetch(bit right_ch, longint delay_q16);
      longint             pos;
      longint             ip;
      longint             fr;
      longint             r0;
      longint             r1;
      logic [RING_AW-1:0] i0;
      logic [RING_AW-1:0] i1;
      pos = (longint'(wr_idx) << 16) - delay_q16;
      ip  = pos >>> 16;
      fr  = pos & 64'hFFFF;
      i0  = ip[RING_AW-1:0];
      i1  = i0 + 1'b1;
      r0  = right_ch ? right_ring[i0] : left_ring[i0];
      r1  = right_ch ? right_ring[i1] : left_ring[i1];
      return r0 + (((r1 - r0) * fr) >>> 16);
    endfunction

    function logic [SMP_W-1:0] blend(longint dry, longint wet);
      longint v;
      v = (dry * (64'sd8192 - longint'(amount)) + wet * longint'(amount) + 4096) >>> 13;
      if (v > 64'sd8388607) begin
        v = 64'sd8388607;
      end
      if (v < -64'sd8388608) begin
        v = -64'sd8388608;
      end
      return v[SMP_W-1:0];
    endfunction

    function void note_request(scdl_in_t req);
      scdl_out_t   res;
      longint      dl;
      longint      dr;
      longint      s0;
      longint      s1;
      longint      fr;
      longint      lfo;
      longint      off;
      longint      base_q16;
      int unsigned k0;
      int unsigned k1;
      dl = req.left_sample;
      dr = req.right_sample;
      if (amount <= BYPASS_MAX) begin
        res.left_out  = req.left_sample;
        res.right_out = req.right_sample;
      end else begin
        phase = phase + PHASE_W'(step);
        k0  = phase >> (32 - SINE_AW);
        k1  = (k0 + 1) % SINE_N;
        fr  = longint'((phase >> (16 - SINE_AW)) & 32'hFFFF);
        s0  = sine_q15[k0];
        s1  = sine_q15[k1];
        lfo = s0 + (((s1 - s0) * fr) >>> 16);
        off = (longint'(depth) * longint'(width) * lfo) >>> 19;
        base_q16 = longint'(base) << 8;
        left_ring[wr_idx]  = req.left_sample;
        right_ring[wr_idx] = req.right_sample;
        res.left_out  = blend(dl, fetch(1'b0, base_q16 + off));
        res.right_out = blend(dr, fetch(1'b1, base_q16 - off));
        wr_idx = wr_idx + 1'b1;
      end
      expected_pairs = {expected_pairs, res};
    endfunction

    function void check_pair(scdl_out_t got);
      scdl_out_t exp_pair;
      if (expected_pairs.size() == 0) begin
        $error("unexpected output pair %h", got);
        fails++;
        return;
      end
      exp_pair = expected_pairs.pop_front();
      if (got.left_out !== exp_pair.left_out) begin
        $error("left_out: expected %0d, got %0d", exp_pair.left_out, got.left_out);
        fails++;
      end
      if (got.right_out !== exp_pair.right_out) begin
        $error("right_out: expected %0d, got %0d", exp_pair.right_out, got.right_out);
        fails++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  scdl_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  scdl_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit              quiet = 1'b0;
  bit              hold_request = 1'b0;
  chorus_predictor pred = new();

  stereo_chorus_delay_line_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 400000);
    $display("stereo_chorus_delay_line_unit_test: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall = !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pred.check_pair(out_data);
    end
  end

  task automatic push_pair(scdl_in_t req);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred.note_request(req);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid and wait for every expected pair, with a bound.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pred.expected_pairs.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pred.expected_pairs.size() > 0) begin
      $error("%0d output pairs never arrived", pred.expected_pairs.size());
      pred.fails++;
      pred.expected_pairs.delete();
    end
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(1023)) - 24'd512;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      CFG_AMOUNT: begin
        case ($urandom_range(5))
          0: return 24'($urandom_range(4));
          1: return 24'd5;
          2: return 24'd8191;
          3: return 24'd4096;
          default: return 24'($urandom_range(5, 8191));
        endcase
      end
      CFG_WIDTH: begin
        case ($urandom_range(4))
          0: return 24'd0;
          1: return 24'd8191;
          2: return 24'd4096;
          default: return 24'($urandom_range(8191));
        endcase
      end
      CFG_STEP: begin
        case ($urandom_range(4))
          0: return 24'd0;
          1: return 24'hFFFFFF;
          2: return 24'($urandom_range(200000));
          default: return 24'($urandom);
        endcase
      end
      default: begin
        case ($urandom_range(4))
          0: return 24'd0;
          1: return 24'd65535;
          default: return 24'($urandom_range(65535));
        endcase
      end
    endcase
  endfunction

  initial begin
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AMOUNT;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // bypass at reset amount
    push_pair('{24'sh7FFFFF, 24'sh7FFFFF});
    push_pair('{24'sh800000, 24'sh800000});
    push_pair('{24'sh000000, 24'shFFFFFF});
    push_pair('{24'shAAAAAA, 24'sh555555});
    settle();
    write_reg(CFG_AMOUNT, 24'd4);
    push_pair('{24'sh123456, 24'shEDCBA9});
    settle();
    // smallest active amount
    write_reg(CFG_AMOUNT, 24'd5);
    push_pair('{24'sh7FFFFF, 24'sh800000});
    push_pair('{24'sh800000, 24'sh7FFFFF});
    settle();
    write_reg(CFG_AMOUNT, 24'd4096);
    push_pair('{24'sh7FFFFF, 24'sh7FFFFF});
    push_pair('{24'sh800000, 24'sh800000});
    push_pair('{24'sh000001, 24'shFFFFFF});
    push_pair('{24'sh555555, 24'shAAAAAA});
    settle();
    // zero delay reads the sample just written
    write_reg(CFG_BASE, 24'd0);
    write_reg(CFG_DEPTH, 24'd0);
    push_pair('{24'sh400000, 24'shC00000});
    push_pair('{24'sh7FFFFF, 24'sh800000});
    settle();
    // registers at their largest values, deepest delays, fastest LFO
    write_reg(CFG_AMOUNT, 24'd8191);
    write_reg(CFG_WIDTH, 24'd8191);
    write_reg(CFG_DEPTH, 24'd65535);
    write_reg(CFG_BASE, 24'd65535);
    write_reg(CFG_STEP, 24'hFFFFFF);
    push_pair('{24'sh7FFFFF, 24'sh800000});
    push_pair('{24'sh800000, 24'sh7FFFFF});
    push_pair('{24'sh3C0F0F, 24'shC3F0F0});
    push_pair('{24'sh000000, 24'sh000000});
    settle();
    write_reg(CFG_STEP, 24'd0);
    write_reg(CFG_WIDTH, 24'd0);
    push_pair('{24'sh012345, 24'shFEDCBA});
    push_pair('{24'sh7FFFFF, 24'sh800000});
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      for (int r = CFG_AMOUNT; r <= CFG_DEPTH; r++) begin
        write_reg(CFG_IDX_W'(r), pick_reg(CFG_IDX_W'(r)));
      end
      quiet = (ph == 2);
      // long receiver hold-off while requests keep coming
      if (ph == 5) begin
        hold_request = 1'b1;
      end
      n = $urandom_range(95, 115);
      repeat (n) push_pair('{rand_sample(), rand_sample()});
      settle();
    end
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (pred.fails == 0) begin
      $display("stereo_chorus_delay_line_unit_test: PASS");
    end else begin
      $display("stereo_chorus_delay_line_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
